/* hw/rtl/mfb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mfb_pkg;

  localparam int MOTOR_COUNT = 16;
  localparam int SLOT_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  localparam logic [10:0] FIRST_FEEDBACK_ID = 11'd257;
  localparam logic [3:0]  FEEDBACK_LENGTH   = 4'd8;
  localparam logic [12:0] FULL_SCALE        = 13'd4096;
  localparam logic [9:0]  BASE_SPEED_RESET  = 10'd200;
  localparam logic [9:0]  SPEED_SPAN_RESET  = 10'd800;

  // Command codes
  localparam logic CMD_FEEDBACK = 1'b0;
  localparam logic CMD_DRIVE    = 1'b1;

  // Configuration register indexes
  localparam logic REG_BASE_SPEED = 1'b0;
  localparam logic REG_SPEED_SPAN = 1'b1;

  typedef struct packed {
    logic        command;
    logic [10:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_payload;
    logic [3:0]  drive_motor;
    logic [12:0] target_position;
  } in_t;

  typedef struct packed {
    logic [3:0]         motor_number;
    logic [10:0]        speed_command;
    logic [11:0]        measured_position;
    logic signed [11:0] measured_velocity;
    logic signed [11:0] measured_current;
  } out_t;

  typedef struct packed {
    logic [11:0] position;
    logic [11:0] velocity;
    logic [11:0] current;
  } entry_t;

endpackage

`default_nettype wire

/* hw/rtl/motor_feedback_table_speed_command_unit.sv */
// A word goes from accept through the input stage to the result stage.
// Throughput: one word per cycle while the output is not stalled; while a result
// waits, a word is taken only if the input stage is empty.
// A valid feedback frame updates the table when accepted and yields no result.
// Reset (synchronous, active high) clears the table to zero, loads base_speed 200
// and speed_span 800, and empties both stages.
`timescale 1ns / 1ps
`default_nettype none

module motor_feedback_table_speed_command_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire mfb_pkg::in_t  in_data,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      mfb_pkg::out_t out_data,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [9:0]    cfg_data
);

  logic [9:0] base_speed;
  logic [9:0] speed_span;

  mfb_pkg::entry_t table_q [mfb_pkg::MOTOR_COUNT];

  logic            s1_valid;
  logic [3:0]      s1_motor;
  logic [12:0]     s1_target;
  mfb_pkg::entry_t s1_entry;

  logic            advance;
  logic            in_accept;
  logic [10:0]     wr_slot;
  logic            wr_en;
  logic [10:0]     rd_slot;
  mfb_pkg::entry_t rd_entry;
  logic [12:0]     target_clamped;
  logic [12:0]     pos_ext;
  logic [12:0]     pos_err;
  logic [22:0]     product;
  logic [10:0]     speed_next;

  assign advance   = !out_valid || out_ready;
  assign in_ready  = !s1_valid || advance;
  assign in_accept = in_valid && in_ready;

  // Feedback frame decode
  assign wr_slot = in_data.frame_id - mfb_pkg::FIRST_FEEDBACK_ID;
  assign wr_en   = in_accept && (in_data.command == mfb_pkg::CMD_FEEDBACK) &&
                   (in_data.frame_length == mfb_pkg::FEEDBACK_LENGTH) &&
                   (in_data.frame_id >= mfb_pkg::FIRST_FEEDBACK_ID) &&
                   (wr_slot < 11'(mfb_pkg::MOTOR_COUNT));

  // Table read; a motor beyond the table reads as zero
  assign rd_slot = {7'd0, in_data.drive_motor};
  always_comb begin
    if (rd_slot < 11'(mfb_pkg::MOTOR_COUNT)) begin
      rd_entry = table_q[rd_slot[mfb_pkg::SLOT_W-1:0]];
    end else begin
      rd_entry = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_speed <= mfb_pkg::BASE_SPEED_RESET;
      speed_span <= mfb_pkg::SPEED_SPAN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mfb_pkg::REG_BASE_SPEED: base_speed <= cfg_data;
        mfb_pkg::REG_SPEED_SPAN: speed_span <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mfb_pkg::MOTOR_COUNT; i++) begin
        table_q[i] <= '0;
      end
    end else if (wr_en) begin
      table_q[wr_slot[mfb_pkg::SLOT_W-1:0]] <= '{
        position: in_data.frame_payload[27:16],
        velocity: in_data.frame_payload[39:28],
        current:  in_data.frame_payload[51:40]
      };
    end
  end

  // Input stage: a full stage holds while the result register is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_accept && (in_data.command == mfb_pkg::CMD_DRIVE);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (in_data.command == mfb_pkg::CMD_DRIVE)) begin
      s1_motor  <= in_data.drive_motor;
      s1_target <= in_data.target_position;
      s1_entry  <= rd_entry;
    end
  end

  // Speed command
  assign target_clamped = (s1_target > mfb_pkg::FULL_SCALE) ? mfb_pkg::FULL_SCALE
                                                            : s1_target;
  assign pos_ext    = {1'b0, s1_entry.position};
  assign pos_err    = (target_clamped >= pos_ext) ? (target_clamped - pos_ext)
                                                  : (pos_ext - target_clamped);
  assign product    = 23'(pos_err) * 23'(speed_span);
  assign speed_next = {1'b0, base_speed} + product[22:12];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_data.motor_number      <= s1_motor;
      out_data.speed_command     <= speed_next;
      out_data.measured_position <= s1_entry.position;
      out_data.measured_velocity <= s1_entry.velocity;
      out_data.measured_current  <= s1_entry.current;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mfb_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module mfb_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire mfb_pkg::out_t out_data
);

  // Stalled result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.speed_command <= 11'd2046)
    else $error("speed command above full scale sum");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled though output drains");

endmodule

bind motor_feedback_table_speed_command_unit mfb_checker u_mfb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mfb_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mfb_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = mfb_pkg::REG_BASE_SPEED;
  logic [9:0] cfg_data = '0;

  motor_feedback_table_speed_command_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow of the feedback table and the speed registers
  logic [11:0] fb_pos [mfb_pkg::MOTOR_COUNT];
  logic [11:0] fb_vel [mfb_pkg::MOTOR_COUNT];
  logic [11:0] fb_cur [mfb_pkg::MOTOR_COUNT];
  logic [9:0] base_speed_now;
  logic [9:0] speed_span_now;
  mfb_pkg::out_t speed_replies_due[$];

  int fails = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  int hold_off_len = 0;
  int stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_off_len > 0) begin
      stall_left = hold_off_len;
      hold_off_len = 0;
    end
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready = 1'b0;
      stall_left = $urandom_range(1, 5) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  function automatic void reset_shadow();
    for (int i = 0; i < mfb_pkg::MOTOR_COUNT; i++) begin
      fb_pos[i] = '0;
      fb_vel[i] = '0;
      fb_cur[i] = '0;
    end
    base_speed_now = mfb_pkg::BASE_SPEED_RESET;
    speed_span_now = mfb_pkg::SPEED_SPAN_RESET;
  endfunction

  // Update the table or queue the speed reply for one accepted word
  function automatic void track_word(mfb_pkg::in_t w);
    mfb_pkg::out_t r;
    logic [3:0] slot;
    int target;
    int pos;
    int gap;
    int speed;
    if (w.command == mfb_pkg::CMD_FEEDBACK) begin
      if (w.frame_length == mfb_pkg::FEEDBACK_LENGTH &&
          w.frame_id >= mfb_pkg::FIRST_FEEDBACK_ID &&
          w.frame_id < mfb_pkg::FIRST_FEEDBACK_ID + mfb_pkg::MOTOR_COUNT) begin
        slot = 4'(w.frame_id - mfb_pkg::FIRST_FEEDBACK_ID);
        fb_pos[slot] = w.frame_payload[27:16];
        fb_vel[slot] = w.frame_payload[39:28];
        fb_cur[slot] = w.frame_payload[51:40];
      end
    end else begin
      r = '0;
      r.motor_number = w.drive_motor;
      if (w.drive_motor < mfb_pkg::MOTOR_COUNT) begin
        r.measured_position = fb_pos[w.drive_motor];
        r.measured_velocity = fb_vel[w.drive_motor];
        r.measured_current = fb_cur[w.drive_motor];
      end
      pos = int'(r.measured_position);
      target = (w.target_position > mfb_pkg::FULL_SCALE) ? int'(mfb_pkg::FULL_SCALE)
                                                         : int'(w.target_position);
      gap = (target >= pos) ? target - pos : pos - target;
      speed = int'(base_speed_now) + ((gap * int'(speed_span_now)) >> 12);
      r.speed_command = speed[10:0];
      speed_replies_due.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : monitor_p
    mfb_pkg::out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (speed_replies_due.size() == 0) begin
          $error("unexpected word for motor %0d", out_data.motor_number);
          fails++;
        end else begin
          want = speed_replies_due.pop_front();
          check_field("motor_number", int'(want.motor_number),
                      int'(out_data.motor_number));
          check_field("speed_command", int'(want.speed_command),
                      int'(out_data.speed_command));
          check_field("measured_position", int'(want.measured_position),
                      int'(out_data.measured_position));
          check_field("measured_velocity", int'($signed(want.measured_velocity)),
                      int'($signed(out_data.measured_velocity)));
          check_field("measured_current", int'($signed(want.measured_current)),
                      int'($signed(out_data.measured_current)));
        end
      end
      if (in_valid && in_ready) track_word(in_data);
    end
  end

  // Called at a falling edge; returns at the falling edge after the accept
  task automatic send_word(input mfb_pkg::in_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_data = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (speed_replies_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [9:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == mfb_pkg::REG_BASE_SPEED) base_speed_now = val;
    else speed_span_now = val;
  endtask

  task automatic set_speed(input logic [9:0] base, input logic [9:0] span);
    wait_drained();
    write_reg(mfb_pkg::REG_BASE_SPEED, base);
    write_reg(mfb_pkg::REG_SPEED_SPAN, span);
  endtask

  // Unused payload bits and drive fields are filled at random
  function automatic logic [63:0] pack_feedback(logic [11:0] pos, logic [11:0] vel,
                                                logic [11:0] cur);
    logic [31:0] noise;
    noise = $urandom();
    return {noise[31:20], cur, vel, pos, noise[15:0]};
  endfunction

  function automatic mfb_pkg::in_t make_frame(logic [10:0] id, logic [3:0] len,
                                              logic [63:0] payload);
    mfb_pkg::in_t w;
    w.command = mfb_pkg::CMD_FEEDBACK;
    w.frame_id = id;
    w.frame_length = len;
    w.frame_payload = payload;
    w.drive_motor = 4'($urandom_range(0, 15));
    w.target_position = 13'($urandom_range(0, 8191));
    return w;
  endfunction

  function automatic mfb_pkg::in_t make_drive(logic [3:0] motor, logic [12:0] target);
    mfb_pkg::in_t w;
    w.command = mfb_pkg::CMD_DRIVE;
    w.frame_id = 11'($urandom_range(0, 2047));
    w.frame_length = 4'($urandom_range(0, 15));
    w.frame_payload = {$urandom(), $urandom()};
    w.drive_motor = motor;
    w.target_position = target;
    return w;
  endfunction

  function automatic mfb_pkg::in_t random_word(output bit useful);
    int pick;
    logic [10:0] id;
    pick = $urandom_range(0, 99);
    useful = 1'b1;
    if (pick < 45) begin
      if ($urandom_range(0, 4) == 0)
        return make_drive(4'($urandom_range(0, 15)), 13'($urandom_range(0, 8191)));
      return make_drive(4'($urandom_range(0, 15)), 13'($urandom_range(0, 4096)));
    end
    if (pick < 80)
      return make_frame(11'(mfb_pkg::FIRST_FEEDBACK_ID +
                            $urandom_range(0, mfb_pkg::MOTOR_COUNT - 1)),
                        mfb_pkg::FEEDBACK_LENGTH, {$urandom(), $urandom()});
    // noise: mostly rejected frames, some near the accepted id range
    useful = 1'b0;
    id = $urandom_range(0, 1) ? 11'($urandom_range(0, 2047)) : 11'($urandom_range(250, 280));
    return make_frame(id, 4'($urandom_range(0, 15)), {$urandom(), $urandom()});
  endfunction

  task automatic test_directed();
    send_word(make_drive(4'd0, 13'd0));
    send_word(make_drive(4'd15, 13'd4096));
    send_word(make_drive(4'd7, 13'd8191));
    send_word(make_frame(11'd257, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    send_word(make_drive(4'd0, 13'd0));
    send_word(make_frame(11'd272, 4'd8, pack_feedback(12'h800, 12'h800, 12'h7FF)));
    send_word(make_drive(4'd15, 13'd4096));
    // rejected frames: id out of range or wrong length
    send_word(make_frame(11'd256, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    send_word(make_frame(11'd273, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    send_word(make_frame(11'd257, 4'd7, 64'h0));
    send_word(make_frame(11'd257, 4'd9, 64'h0));
    send_word(make_frame(11'd257, 4'd15, 64'h0));
    send_word(make_frame(11'd2047, 4'd15, 64'h0));
    send_word(make_frame(11'd0, 4'd0, 64'h0));
    send_word(make_drive(4'd0, 13'd4096));
    send_word(make_drive(4'd15, 13'd0));
    // only the unused payload bits set
    send_word(make_frame(11'd258, 4'd8, 64'hFFF0_0000_0000_FFFF));
    send_word(make_drive(4'd1, 13'd2048));
    send_word(make_frame(11'd258, 4'd8, pack_feedback(12'h7FF, 12'h7FF, 12'h800)));
    send_word(make_drive(4'd1, 13'd8191));
    wait_drained();
  endtask

  task automatic test_register_extremes();
    logic [9:0] bases [5];
    logic [9:0] spans [5];
    bases = '{10'd0, 10'd1023, 10'd0, 10'd1023, 10'($urandom_range(0, 1023))};
    spans = '{10'd0, 10'd1023, 10'd1023, 10'd0, 10'($urandom_range(0, 1023))};
    send_word(make_frame(11'd260, 4'd8, pack_feedback(12'd0, 12'd5, 12'd9)));
    send_word(make_frame(11'd261, 4'd8, pack_feedback(12'hFFF, 12'hFFB, 12'hFF7)));
    for (int i = 0; i < 5; i++) begin
      set_speed(bases[i], spans[i]);
      send_word(make_drive(4'd3, 13'd4096));
      send_word(make_drive(4'd4, 13'd0));
      send_word(make_drive(4'd3, 13'd0));
      send_word(make_drive(4'd4, 13'($urandom_range(0, 8191))));
    end
    wait_drained();
  endtask

  // Hold the receiver off so the block fills and stalls its input
  task automatic test_output_hold_off();
    idle_on = 1'b0;
    hold_off_len = 80;
    for (int i = 0; i < 40; i++)
      send_word(make_drive(4'($urandom_range(0, 15)), 13'($urandom_range(0, 4096))));
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    bit useful;
    for (int i = 0; i < 12; i++) send_word(random_word(useful));
    wait_drained();
    for (int i = 0; i < 12; i++) send_word(random_word(useful));
    wait_drained();
  endtask

  task automatic test_random();
    bit useful;
    int sent;
    for (int chunk = 0; chunk < 4; chunk++) begin
      if (chunk == 1) set_speed(10'd1023, 10'd1023);
      else set_speed(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      // last stretch runs without idling
      idle_on = (chunk != 3);
      sent = 0;
      while (sent < 120) begin
        send_word(random_word(useful));
        if (useful) sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    reset_shadow();
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_register_extremes();
    test_output_hold_off();
    test_sender_pause();
    test_random();
    repeat (8) @(negedge clk);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
